// ===== rtl/core/fixed_point_alu_assert.svh =====
// Assertion macros used by the fixed-point ALU top level.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet during reset.
`define FPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset.
`define FPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fpa_pkg.sv =====
// Types and constants of the fixed-point ALU.
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_BITS = 32;
	localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;

	typedef enum logic [3:0] {
		CMD_ADD      = 4'd0,
		CMD_SUB      = 4'd1,
		CMD_MUL      = 4'd2,
		CMD_DIV      = 4'd3,
		CMD_MIN      = 4'd4,
		CMD_MAX      = 4'd5,
		CMD_INC      = 4'd6,
		CMD_DEC      = 4'd7,
		CMD_FROM_INT = 4'd8,
		CMD_TO_INT   = 4'd9
	} cmd_e;

	typedef struct packed {
		logic [3:0]                  cmd;
		logic signed [WORD_BITS-1:0] operand_a;
		logic signed [WORD_BITS-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] result_word;
		logic                        a_less;
		logic                        a_equal;
		logic                        a_greater;
		logic                        divide_by_zero;
	} out_t;

	// What travels down the divider chain with each item.
	typedef struct packed {
		logic                 is_div;
		logic                 neg;
		logic                 dz;
		logic [WORD_BITS-1:0] rem;
		logic [WORD_BITS-1:0] den;
		logic [DIV_BITS-1:0]  dvd;
		logic [WORD_BITS-1:0] res;
		logic                 lt;
		logic                 eq;
		logic                 gt;
	} cell_t;

endpackage

// ===== rtl/core/fpa_div_cell.sv =====
// One restoring-division cell: retires one quotient bit and registers the item.
module fpa_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  fpa_pkg::cell_t up,
	output logic          dn_valid,
	input  logic          dn_ready,
	output fpa_pkg::cell_t dn
);
	import fpa_pkg::*;

	logic                 valid_q;
	cell_t                data_q;
	cell_t                nxt;
	logic [WORD_BITS:0]   trial;
	logic [WORD_BITS:0]   diff;
	logic                 ge;

	assign up_ready = !valid_q || dn_ready;
	assign dn_valid = valid_q;
	assign dn       = data_q;

	always_comb begin
		trial = {up.rem, up.dvd[DIV_BITS-1]};
		diff  = trial - {1'b0, up.den};
		ge    = (trial >= {1'b0, up.den});
		nxt   = up;
		nxt.rem = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
		// shift the next quotient bit in where the dividend bit left
		nxt.dvd = {up.dvd[DIV_BITS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== rtl/core/fpa_front.sv =====
// Input stage: registers the operands and product, then prepares the chain entry.
module fpa_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fpa_pkg::in_t  req,
	output logic          dn_valid,
	input  logic          dn_ready,
	output fpa_pkg::cell_t dn
);
	import fpa_pkg::*;

	logic                          valid_s1;
	logic [3:0]                    cmd_s1;
	logic signed [WORD_BITS-1:0]   a_s1;
	logic signed [WORD_BITS-1:0]   b_s1;
	logic signed [2*WORD_BITS-1:0] prod_s1;
	logic signed [2*WORD_BITS-1:0] prod_sh;
	logic [WORD_BITS-1:0]          abs_a;
	logic [WORD_BITS-1:0]          res;

	assign req_ready = !valid_s1 || dn_ready;
	assign dn_valid  = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			cmd_s1  <= req.cmd;
			a_s1    <= req.operand_a;
			b_s1    <= req.operand_b;
			prod_s1 <= 64'(req.operand_a) * 64'(req.operand_b);
		end
	end

	always_comb begin
		prod_sh = prod_s1 >>> FRAC_BITS;
		abs_a   = a_s1[WORD_BITS-1] ? (~a_s1 + 1'b1) : a_s1;
		unique case (cmd_s1)
			CMD_ADD:      res = a_s1 + b_s1;
			CMD_SUB:      res = a_s1 - b_s1;
			CMD_MUL:      res = prod_sh[WORD_BITS-1:0];
			CMD_MIN:      res = (a_s1 <= b_s1) ? a_s1 : b_s1;
			CMD_MAX:      res = (a_s1 >= b_s1) ? a_s1 : b_s1;
			CMD_INC:      res = a_s1 + 1'b1;
			CMD_DEC:      res = a_s1 - 1'b1;
			CMD_FROM_INT: res = a_s1 << FRAC_BITS;
			CMD_TO_INT:   res = a_s1 >>> FRAC_BITS;
			default:      res = '0;
		endcase
		dn.is_div = (cmd_s1 == CMD_DIV);
		dn.neg    = a_s1[WORD_BITS-1] ^ b_s1[WORD_BITS-1];
		dn.dz     = (b_s1 == '0);
		dn.rem    = '0;
		dn.den    = b_s1[WORD_BITS-1] ? (~b_s1 + 1'b1) : b_s1;
		dn.dvd    = {abs_a, {FRAC_BITS{1'b0}}};
		dn.res    = res;
		dn.lt     = (a_s1 < b_s1);
		dn.eq     = (a_s1 == b_s1);
		dn.gt     = (a_s1 > b_s1);
	end

endmodule

// ===== rtl/core/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU.
// Usage:
//   The request channel (req_valid/req_ready/req) carries cmd, operand_a and
//   operand_b; the response channel (rsp_valid/rsp_ready/rsp) returns one
//   result word with less/equal/greater flags and a divide-by-zero flag.
//   Every item flows through the same pipeline: an input register with the
//   32x32 multiplier, DIV_BITS (= 32 + FRAC_BITS, 40 by default) division
//   cells that each retire one quotient bit, and an output register.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the one-bit-per-cell division chain; items leave in request order.
//   A stalled receiver holds the output register; each stage still accepts
//   while the stage below it is empty, so bubbles close up before req_ready
//   drops. Reset clears all valid flags; the block takes items right away.
module fixed_point_alu (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  fpa_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output fpa_pkg::out_t rsp
);
	import fpa_pkg::*;

	logic  link_valid [DIV_BITS+1];
	logic  link_ready [DIV_BITS+1];
	cell_t link       [DIV_BITS+1];

	logic                 rsp_valid_q;
	out_t                 rsp_q;
	logic                 out_ready;
	logic [WORD_BITS-1:0] quot;
	out_t                 rsp_nxt;

	fpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.dn_valid  (link_valid[0]),
		.dn_ready  (link_ready[0]),
		.dn        (link[0])
	);

	for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[i]),
			.up_ready (link_ready[i]),
			.up       (link[i]),
			.dn_valid (link_valid[i+1]),
			.dn_ready (link_ready[i+1]),
			.dn       (link[i+1])
		);
	end

	assign out_ready             = !rsp_valid_q || rsp_ready;
	assign link_ready[DIV_BITS]  = out_ready;

	always_comb begin
		quot = link[DIV_BITS].dvd[WORD_BITS-1:0];
		rsp_nxt.result_word = link[DIV_BITS].res;
		if (link[DIV_BITS].is_div) begin
			if (link[DIV_BITS].dz) begin
				rsp_nxt.result_word = '0;
			end else if (link[DIV_BITS].neg) begin
				rsp_nxt.result_word = ~quot + 1'b1;
			end else begin
				rsp_nxt.result_word = quot;
			end
		end
		rsp_nxt.a_less         = link[DIV_BITS].lt;
		rsp_nxt.a_equal        = link[DIV_BITS].eq;
		rsp_nxt.a_greater      = link[DIV_BITS].gt;
		rsp_nxt.divide_by_zero = link[DIV_BITS].is_div && link[DIV_BITS].dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ready) begin
			rsp_valid_q <= link_valid[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && link_valid[DIV_BITS]) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "fixed_point_alu_assert.svh"

	`FPA_ASSERT_IMP(a_flags_onehot, rsp_valid_q,
		$onehot({rsp_q.a_less, rsp_q.a_equal, rsp_q.a_greater}), "compare flags not one-hot")
	`FPA_ASSERT_IMP(a_dz_zero, rsp_valid_q && rsp_q.divide_by_zero,
		rsp_q.result_word == '0, "divide by zero with nonzero result")
	`FPA_ASSERT_IMP(a_stall_full, !req_ready, rsp_valid_q, "input stalled with empty output")
	`FPA_ASSERT_NXT(a_hold_result, rsp_valid_q && !rsp_ready, rsp_valid_q, "result dropped")

endmodule
